### design/rgma_pkg.sv
// Shared constants, types and register codes for the range-gated moving average unit.
// No dependencies; imported by every module of the block.
package rgma_pkg;

  localparam int WINDOW      = 8;   // power of two: the mean is a right shift
  localparam int MAX_ACCEPT  = 64;
  localparam int SAMPLE_BITS = 12;

  localparam int SAMPLE_W = 12;     // port width of the raw reading
  localparam int GAIN_W   = 16;
  localparam int AVG_W    = 16;
  localparam int LIMIT_W  = 7;
  localparam int CNT_W    = $clog2(MAX_ACCEPT) + 1;
  localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW);
  localparam int PROD_W   = GAIN_W + SUM_W;
  localparam int DIV_SHIFT = $clog2(WINDOW * 256);
  localparam int Q_W      = PROD_W - DIV_SHIFT;
  localparam int V_W      = ((Q_W > AVG_W) ? Q_W : AVG_W) + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 3'd4;

  localparam logic [SAMPLE_BITS-1:0] MIN_RAW_RST = SAMPLE_BITS'(200);
  localparam logic [SAMPLE_BITS-1:0] MAX_RAW_RST = SAMPLE_BITS'(3800);
  localparam logic [GAIN_W-1:0]      GAIN_RST    = GAIN_W'(1600);
  localparam logic signed [AVG_W-1:0] OFFSET_RST = -AVG_W'(2560);
  localparam logic [LIMIT_W-1:0]     LIMIT_RST   = LIMIT_W'(64);

  // Per-item control carried down the result pipeline
  typedef struct packed {
    logic             emit;   // a mean result is due
    logic             last;   // batch end: a count result is due
    logic [CNT_W-1:0] count;  // means emitted in the batch after this item
  } item_t;

endpackage

### design/rgma_cell.sv
// One tap of the sample window: holds a sample and passes it on when the window shifts.
// Depends on rgma_pkg.
module rgma_cell (
  input  logic                             clk_i,
  input  logic                             shift_i,
  input  logic [rgma_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic [rgma_pkg::SAMPLE_BITS-1:0] sample_o
);
  import rgma_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

### design/rgma_calib.sv
// Calibration stage: registered gain * window sum, then shift, offset add and 16-bit clamp.
// Depends on rgma_pkg.
module rgma_calib (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic [rgma_pkg::GAIN_W-1:0]       gain_i,
  input  logic [rgma_pkg::SUM_W-1:0]        sum_i,
  input  logic signed [rgma_pkg::AVG_W-1:0] offset_i,
  output logic signed [rgma_pkg::AVG_W-1:0] mean_o
);
  import rgma_pkg::*;

  localparam logic signed [V_W-1:0] SAT_HI = V_W'(32767);
  localparam logic signed [V_W-1:0] SAT_LO = -V_W'(32768);

  logic [PROD_W-1:0]       prod_q;
  logic [Q_W-1:0]          scaled;
  logic signed [V_W-1:0]   biased;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= PROD_W'(gain_i) * PROD_W'(sum_i);
    end
  end

  // floor division by WINDOW*256 is a plain shift of the unsigned product
  assign scaled = prod_q[PROD_W-1:DIV_SHIFT];
  assign biased = $signed(V_W'(scaled)) + V_W'(offset_i);

  always_comb begin
    if (biased > SAT_HI) begin
      mean_o = AVG_W'(SAT_HI);
    end else if (biased < SAT_LO) begin
      mean_o = AVG_W'(SAT_LO);
    end else begin
      mean_o = AVG_W'(biased);
    end
  end

endmodule

### design/range_gated_moving_average_unit.sv
// Range-gated moving average: an input transfer passes stage A, stage B and the output
// register in turn. Throughput one sample per cycle while the output does not stall;
// a batch end that also emits a mean holds stage B, since the mean and count results
// leave one per cycle from one register.
// Reset (async, active low) restores the register defaults and clears the batch
// counters and running sum; the window taps are left as they are.
module range_gated_moving_average_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rgma_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rgma_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rgma_pkg::SAMPLE_W-1:0]        sample_i,
  input  logic                                 batch_end_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rgma_pkg::AVG_W-1:0]    average_o,
  output logic                                 is_count_o,
  output logic [rgma_pkg::CNT_W-1:0]           result_count_o,
  output logic                                 run_end_o
);
  import rgma_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never back-pressures.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]  min_raw_q, max_raw_q;
  logic [GAIN_W-1:0]       gain_q;
  logic signed [AVG_W-1:0] offset_q;
  logic [LIMIT_W-1:0]      limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_raw_q <= MIN_RAW_RST;
      max_raw_q <= MAX_RAW_RST;
      gain_q    <= GAIN_RST;
      offset_q  <= OFFSET_RST;
      limit_q   <= LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_RAW:      min_raw_q <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_MAX_RAW:      max_raw_q <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_GAIN:         gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_OFFSET:       offset_q  <= $signed(cfg_data_i[AVG_W-1:0]);
        CFG_OUTPUT_LIMIT: limit_q   <= cfg_data_i[LIMIT_W-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Stage A holds the new window sum, stage B the
  // product, then the output register. in_stall is raised only while A and B
  // are full and B cannot move on: the output is stalled or a second result is due.
  // ---------------------------------------------------------------------------
  logic  valid_a_q, valid_b_q, mean_done_q;
  item_t item_a_q, item_b_q;
  logic  out_free, two_left, b_done, b_take, a_take, accept;

  assign out_free = !out_valid_o || !out_stall_i;
  // batch end that also emits: mean goes first, B holds for the count
  assign two_left = item_b_q.emit && item_b_q.last && !mean_done_q;
  assign b_done   = valid_b_q && out_free && !two_left;
  assign b_take   = !valid_b_q || b_done;
  assign a_take   = !valid_a_q || b_take;
  assign in_stall_o = !a_take;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Sample gate and batch state
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] s;
  logic [CNT_W-1:0]       accepted_q, emitted_q, acc_inc, emit_cnt;
  logic [SUM_W-1:0]       sum_q, sum_d, drop;
  logic                   gate, take, window_full, emit;

  assign s           = sample_i[SAMPLE_BITS-1:0];
  assign gate        = (s >= min_raw_q) && (s <= max_raw_q) &&
                       (accepted_q < CNT_W'(MAX_ACCEPT));
  assign take        = accept && gate;
  assign window_full = accepted_q >= CNT_W'(WINDOW);
  assign acc_inc     = accepted_q + CNT_W'(1);
  assign emit        = take && (acc_inc >= CNT_W'(WINDOW)) &&
                       (CNT_W'(emitted_q) < CNT_W'(limit_q));
  assign emit_cnt    = emitted_q + CNT_W'(emit);

  // ---------------------------------------------------------------------------
  // Window: a row of cells shifting on every accepted sample. The last tap
  // holds the sample that leaves the running sum once the window is full.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] tap [WINDOW+1];

  assign tap[0] = s;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    rgma_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (take),
      .sample_i (tap[g]),
      .sample_o (tap[g+1])
    );
  end

  assign drop  = window_full ? SUM_W'(tap[WINDOW]) : '0;
  assign sum_d = take ? (sum_q - drop + SUM_W'(s)) : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_q <= '0;
      emitted_q  <= '0;
      sum_q      <= '0;
    end else if (accept) begin
      if (batch_end_i) begin
        accepted_q <= '0;
        emitted_q  <= '0;
        sum_q      <= '0;
      end else begin
        if (take) begin
          accepted_q <= acc_inc;
        end
        emitted_q <= emit_cnt;
        sum_q     <= sum_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: snapshot of the sum for items that produce a result
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (a_take) begin
      valid_a_q <= accept && (emit || batch_end_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      item_a_q.emit  <= emit;
      item_a_q.last  <= batch_end_i;
      item_a_q.count <= emit_cnt;
      sum_a_q        <= sum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: product register lives in the calibration unit
  // ---------------------------------------------------------------------------
  logic signed [AVG_W-1:0] mean;

  rgma_calib u_calib (
    .clk_i    (clk_i),
    .load_i   (b_take),
    .gain_i   (gain_q),
    .sum_i    (sum_a_q),
    .offset_i (offset_q),
    .mean_o   (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q   <= 1'b0;
      mean_done_q <= 1'b0;
    end else begin
      if (b_take) begin
        valid_b_q   <= valid_a_q;
        mean_done_q <= 1'b0;
      end else if (valid_b_q && out_free && two_left) begin
        mean_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_take) begin
      item_b_q <= item_a_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: mean result first, count result on batch end
  // ---------------------------------------------------------------------------
  logic                    out_valid_q;
  logic signed [AVG_W-1:0] average_q;
  logic                    is_count_q, run_end_q;
  logic [CNT_W-1:0]        count_q;
  logic                    send_mean;

  assign send_mean = item_b_q.emit && !mean_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && valid_b_q) begin
      if (send_mean) begin
        average_q  <= mean;
        is_count_q <= 1'b0;
        count_q    <= '0;
        run_end_q  <= !item_b_q.last;
      end else begin
        average_q  <= '0;
        is_count_q <= 1'b1;
        count_q    <= item_b_q.count;
        run_end_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_o      = average_q;
  assign is_count_o     = is_count_q;
  assign result_count_o = count_q;
  assign run_end_o      = run_end_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted_q <= CNT_W'(MAX_ACCEPT))
    else $error("accepted count above limit");

  a_emit_le_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= accepted_q)
    else $error("more means than accepted samples");

  a_batch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && batch_end_i |=> accepted_q == '0 && emitted_q == '0 && sum_q == '0)
    else $error("batch state not cleared after batch end");

  a_count_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_count_o |-> average_o == '0 && run_end_o)
    else $error("malformed count result");

  a_mean_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_count_o |-> result_count_o == '0)
    else $error("mean result carries a count");

endmodule

### tb/tb_range_gated_moving_average_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for range_gated_moving_average_unit: directed and random batches,
// with a transfer-level predictor of the gated 8-tap mean. Depends on rgma_pkg and the unit.
module tb_range_gated_moving_average_unit;
  import rgma_pkg::*;

  localparam int     REPORT_MAX  = 10;    // mismatches printed in full
  localparam int     QUIET_LIMIT = 1000;  // cycles with no transfer before the run is called hung
  localparam int     DRAIN_WAIT  = 8;     // pipeline is 3 deep; margin for items that emit nothing
  localparam int     RANDOM_ITEMS = 400;
  localparam longint AVG_HI = 2 ** (AVG_W - 1) - 1;
  localparam longint AVG_LO = -(2 ** (AVG_W - 1));

  // One result transfer as seen on the output port
  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             is_count;
    logic [CNT_W-1:0] count;
    logic             run_end;
  } filter_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [SAMPLE_W-1:0]     sample_i;
  logic                    batch_end_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [AVG_W-1:0] average_o;
  logic                    is_count_o;
  logic [CNT_W-1:0]        result_count_o;
  logic                    run_end_o;

  range_gated_moving_average_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .sample_i, .batch_end_i,
    .out_valid_o, .out_stall_i, .average_o, .is_count_o, .result_count_o, .run_end_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register copy plus batch state, advanced once per input transfer
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]     lo_thr, hi_thr;
  logic [GAIN_W-1:0]       gain_q16;
  logic signed [AVG_W-1:0] ofs_q88;
  logic [LIMIT_W-1:0]      out_cap;
  logic [SAMPLE_W-1:0]     taps [WINDOW];
  logic [SUM_W-1:0]        run_sum;
  int                      taken;        // samples let through the gate this batch
  int                      sent;         // means emitted this batch

  filter_result_t awaited_results [$];   // results predicted but not yet seen

  // bookkeeping
  int  fail_count, results_seen, samples_sent, items_fed, reg_writes;
  bit  idle_on = 1'b1;                   // random gaps and stalls enabled
  int  src_quiet, sink_left;

  function automatic void clear_batch_state();
    run_sum = '0;
    taken   = 0;
    sent    = 0;
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MIN_RAW:      lo_thr   = data[SAMPLE_W-1:0];
      CFG_MAX_RAW:      hi_thr   = data[SAMPLE_W-1:0];
      CFG_GAIN:         gain_q16 = data[GAIN_W-1:0];
      CFG_OFFSET:       ofs_q88  = data[AVG_W-1:0];
      CFG_OUTPUT_LIMIT: out_cap  = data[LIMIT_W-1:0];
      default: ;  // indexes past the list have no register
    endcase
  endfunction

  // Runs one sample through the gate and window; queues the mean and/or count it causes.
  // Returns 1 when the item did anything (passed the gate or closed the batch).
  function automatic bit compute_window_results(input logic [SAMPLE_W-1:0] s,
                                                input logic last);
    filter_result_t r;
    longint         mean;
    int             slot;
    bit             passed;
    passed = (s >= lo_thr) && (s <= hi_thr) && (taken < MAX_ACCEPT);
    if (passed) begin
      slot = taken % WINDOW;
      // oldest tap drops out only once the window has filled
      if (taken >= WINDOW) run_sum = run_sum - SUM_W'(taps[slot]);
      taps[slot] = s;
      run_sum    = run_sum + SUM_W'(s);
      taken++;
      if (taken >= WINDOW && sent < out_cap) begin
        // gain*sum/(8*256): fixed-point form of the float calibration
        mean = ((longint'(gain_q16) * longint'(run_sum)) >> DIV_SHIFT) + longint'(ofs_q88);
        if (mean > AVG_HI) mean = AVG_HI;
        if (mean < AVG_LO) mean = AVG_LO;
        r.average  = mean[AVG_W-1:0];
        r.is_count = 1'b0;
        r.count    = '0;
        r.run_end  = !last;
        awaited_results.push_back(r);
        sent++;
      end
    end
    if (last) begin
      r.average  = '0;
      r.is_count = 1'b1;
      r.count    = CNT_W'(sent);
      r.run_end  = 1'b1;
      awaited_results.push_back(r);
      clear_batch_state();
    end
    return passed || last;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks; each is entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    store_setting(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);  // keeps the drop and the next raise in different steps
  endtask

  // Writes all five registers; unused upper data bits carry noise
  task automatic apply_settings(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi,
                                input logic [GAIN_W-1:0] g, input logic [AVG_W-1:0] o,
                                input logic [LIMIT_W-1:0] cap);
    write_reg(CFG_MIN_RAW,      {(CFG_DATA_W - SAMPLE_W)'($urandom), lo});
    write_reg(CFG_MAX_RAW,      {(CFG_DATA_W - SAMPLE_W)'($urandom), hi});
    write_reg(CFG_GAIN,         g);
    write_reg(CFG_OFFSET,       o);
    write_reg(CFG_OUTPUT_LIMIT, {(CFG_DATA_W - LIMIT_W)'($urandom), cap});
  endtask

  // One sample transfer. Valid stays high on return so back-to-back items need no
  // second assignment in a step; settle() drops it.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
    if (src_quiet > 0) begin
      src_quiet--;
    end else if (idle_on && $urandom_range(0, 1) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
      src_quiet = $urandom_range(0, 30);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= s;
    batch_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
    if (compute_window_results(s, last)) items_fed++;
    @(negedge clk_i);
  endtask

  // Mostly inside the current gate, some anywhere, a few on the rails
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return roll[0] ? '1 : '0;
    if (roll < 20 || lo_thr > hi_thr) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(hi_thr, lo_thr));
  endfunction

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // Idle the input, let every predicted result come out, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset registers: gate 200..3800, default calibration, limit 64
  task automatic test_gating_and_window();
    // rails and codes just past each threshold are dropped
    send_sample(12'd0, 1'b0);
    send_sample(12'd199, 1'b0);
    send_sample(12'd3801, 1'b0);
    send_sample(12'hFFF, 1'b0);
    // thresholds are inclusive; nothing comes out until the eighth sample passes
    send_sample(12'd200, 1'b0);
    send_sample(12'd3800, 1'b0);
    send_sample(12'd200, 1'b0);
    send_sample(12'd3800, 1'b0);
    send_sample(12'd1024, 1'b0);
    send_sample(12'd2048, 1'b0);
    send_sample(12'd3000, 1'b0);
    send_sample(12'd2500, 1'b0);   // window full: first mean
    send_sample(12'd3800, 1'b0);   // window slides, oldest tap drops out
    // batch end on a dropped sample: count only
    send_sample(12'd199, 1'b1);
    // batch end before the window fills
    send_sample(12'd500, 1'b1);
    // batch with nothing accepted
    send_sample(12'hFFF, 1'b1);
    // batch end on a sample that also emits: mean then count
    for (int i = 0; i < 8; i++) send_sample(SAMPLE_W'(300 + i * 400), i == 7);
  endtask

  task automatic test_register_extremes();
    // full-scale gain and offset: means saturate high
    settle();
    apply_settings('0, '1, '1, 16'h7FFF, LIMIT_W'(MAX_ACCEPT));
    repeat (9) send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    // zero gain, most negative offset
    settle();
    apply_settings('0, '1, '0, 16'h8000, LIMIT_W'(MAX_ACCEPT));
    send_batch(10);
    // crossed thresholds: nothing passes, only the count comes out
    settle();
    apply_settings('1, '0, GAIN_W'($urandom), AVG_W'($urandom), LIMIT_W'(MAX_ACCEPT));
    send_batch(12);
    // output limit zero: window runs but emits nothing
    settle();
    apply_settings('0, '1, GAIN_W'($urandom), AVG_W'($urandom), '0);
    send_batch(14);
    // one-code gate and output limit one
    settle();
    apply_settings(12'd2048, 12'd2048, GAIN_W'($urandom), AVG_W'($urandom), LIMIT_W'(1));
    for (int i = 0; i < 20; i++)
      send_sample(i[0] ? (i[1] ? 12'd2047 : 12'd2049) : 12'd2048, i == 19);
    // indexes past the register list must leave the settings alone
    settle();
    for (int idx = CFG_OUTPUT_LIMIT + 1; idx < 2 ** CFG_IDX_W; idx++)
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    send_batch(12);
  endtask

  // More than MAX_ACCEPT samples in gate: the rest of the batch is ignored
  task automatic test_accept_limit();
    settle();
    apply_settings('0, '1, GAIN_W'($urandom), AVG_W'($urandom), LIMIT_W'(MAX_ACCEPT));
    for (int i = 0; i < MAX_ACCEPT + 8; i++) send_sample(SAMPLE_W'($urandom), 1'b0);
    send_sample(SAMPLE_W'($urandom), 1'b1);
    settle();
    apply_settings(12'd1000, 12'd3000, GAIN_W'($urandom), AVG_W'($urandom), LIMIT_W'(10));
    send_batch(MAX_ACCEPT + 16);
  endtask

  task automatic test_random_batches();
    int                  target, roll;
    logic [SAMPLE_W-1:0] lo, hi;
    logic [GAIN_W-1:0]   g;
    logic [LIMIT_W-1:0]  cap;
    target = samples_sent + RANDOM_ITEMS;
    while (samples_sent < target) begin
      settle();
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        lo = '0;
        hi = '1;
      end else if (roll < 20) begin
        lo = SAMPLE_W'($urandom_range(2049, 4095));   // crossed
        hi = SAMPLE_W'($urandom_range(0, 2048));
      end else begin
        lo = SAMPLE_W'($urandom_range(0, 1500));
        hi = SAMPLE_W'($urandom_range(2500, 4095));
      end
      roll = $urandom_range(0, 9);
      g    = (roll == 0) ? '0 : (roll == 1) ? '1 : GAIN_W'($urandom);
      roll = $urandom_range(0, 9);
      cap  = (roll == 0) ? '0 : (roll == 1) ? LIMIT_W'(1) : (roll == 2) ? LIMIT_W'(MAX_ACCEPT)
           : LIMIT_W'($urandom_range(0, MAX_ACCEPT));
      apply_settings(lo, hi, g, AVG_W'($urandom), cap);
      // last stretch at full rate on both sides
      if (target - samples_sent < 120) idle_on = 1'b0;
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 99) < 85) send_batch($urandom_range(1, 24));
        else send_batch($urandom_range(MAX_ACCEPT - 4, MAX_ACCEPT + 16));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts with free stretches between them
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (sink_left > 0) begin
      sink_left--;
    end else if (idle_on && !out_stall_i) begin
      out_stall_i <= 1'b1;
      sink_left = $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
      sink_left = $urandom_range(0, 40);
    end
  end

  // Result checker: every output transfer against the oldest prediction
  always @(posedge clk_i) begin : result_check
    filter_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: average %0d is_count %0b count %0d run_end %0b",
                   average_o, is_count_o, result_count_o, run_end_o);
      end else begin
        want = awaited_results.pop_front();
        if (want.average !== average_o || want.is_count !== is_count_o ||
            want.count !== result_count_o || want.run_end !== run_end_o) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"mismatch at %0t: expected avg %0d cnt %0b/%0d end %0b, ",
                      "got avg %0d cnt %0b/%0d end %0b"},
                     $realtime, $signed(want.average), want.is_count, want.count, want.run_end,
                     average_o, is_count_o, result_count_o, run_end_o);
        end
      end
    end
  end

  // Hang detector: any transfer on any channel counts as progress
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without a transfer, %0d results still due",
             quiet, awaited_results.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    batch_end_i = 1'b0;
    lo_thr   = MIN_RAW_RST;
    hi_thr   = MAX_RAW_RST;
    gain_q16 = GAIN_RST;
    ofs_q88  = OFFSET_RST;
    out_cap  = LIMIT_RST;
    clear_batch_state();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_gating_and_window();
    test_register_extremes();
    test_accept_limit();
    test_random_batches();
    settle();

    if (awaited_results.size() != 0) begin
      fail_count += awaited_results.size();
      $display("%0d predicted results never arrived", awaited_results.size());
    end
    $display("covered %0d sample transfers (%0d gated in or closing a batch), %0d results",
             samples_sent, items_fed, results_seen);
    $display("with %0d register writes across gate, gain, offset and limit extremes",
             reg_writes);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
